[rtl/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg
// Shared constants and types for the multiplexer switch scanner.
// ----------------------------------------------------------------------------
package mss_pkg;

  // Scan limits
  localparam int MAX_SWITCHES     = 64;
  localparam int MAX_INPUT_LINES  = 8;
  localparam int MAX_SELECT_LINES = 5;

  // Derived widths
  localparam int SW_IDX_W = $clog2(MAX_SWITCHES);      // switch index / bit number
  localparam int SW_CNT_W = SW_IDX_W + 1;              // holds MAX_SWITCHES itself

  // Field widths
  localparam int SEL_W   = 5;
  localparam int LVL_W   = 8;
  localparam int LINE_W  = 3;
  localparam int STATE_W = 64;

  // Configuration register indexes
  localparam logic [1:0] REG_SELECT_LINES = 2'd0;
  localparam logic [1:0] REG_INPUT_LINES  = 2'd1;
  localparam logic [1:0] REG_NEG_LOGIC    = 2'd2;
  localparam logic [1:0] REG_SETTLE_TICKS = 2'd3;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // Middle stage contents
  typedef struct packed {
    logic [SEL_W-1:0] drive;
    logic             done;
    logic             hit;
    logic             err;
  } mss_stage_t;

endpackage

[rtl/mux_switch_scanner_unit.sv]
// ----------------------------------------------------------------------------
// mux_switch_scanner_unit
// Switch scanner for switches behind analog multiplexers.
// ----------------------------------------------------------------------------
// Every input item produces exactly one result item. A tick item (tuser 0)
// carries the sampled input line levels; the result gives the select line
// drive for the switch handled on that tick, tlast when that tick closed a
// scan, and the switch bitmap published by the last completed scan. A map item
// (tuser 1) assigns a bit number to the switch at (line, multiplexer channel)
// and flags a bad line or channel in map_error. Throughput is one item per
// clock while out_tready does not stall the output. The first stage updates
// the scan counters and reads the 64-entry map memory at the scanned switch,
// the second ORs the mapped bit into the accumulator and publishes it at the
// end of a scan. The map memory needs no clearing pass: a per-entry valid
// flop bank is cleared by reset. Write configuration only while no item is
// in flight.
// ----------------------------------------------------------------------------
module mux_switch_scanner_unit
  import mss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [7:0]         cfg_wdata,
  // Input items
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [23:0]        in_tdata,   // input_levels[7:0], map_line[10:8],
                                         // map_mux_pin[15:11], map_number[21:16], zero
  input  logic               in_tuser,   // operation
  // Result items
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [71:0]        out_tdata,  // select_lines[4:0], switch_state[68:5],
                                         // map_error[69], zero
  output logic               out_tlast   // scan_done
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0] cfg_sel_r;
  logic [3:0] cfg_lines_r;
  logic       cfg_neg_r;
  logic [7:0] cfg_settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sel_r    <= 3'd3;
      cfg_lines_r  <= 4'd8;
      cfg_neg_r    <= 1'b1;
      cfg_settle_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SELECT_LINES: cfg_sel_r    <= cfg_wdata[2:0];
        REG_INPUT_LINES:  cfg_lines_r  <= cfg_wdata[3:0];
        REG_NEG_LOGIC:    cfg_neg_r    <= cfg_wdata[0];
        REG_SETTLE_TICKS: cfg_settle_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the registers to their usable ranges
  logic [2:0]          eff_sel;
  logic [3:0]          eff_lines;
  logic [SEL_W-1:0]    sel_mask;
  logic [8:0]          count_raw;
  logic [SW_CNT_W-1:0] sw_count;
  logic [7:0]          settle_need;

  always_comb begin
    if (cfg_sel_r == 3'd0)                         eff_sel = 3'd1;
    else if (cfg_sel_r > 3'(MAX_SELECT_LINES))     eff_sel = 3'(MAX_SELECT_LINES);
    else                                           eff_sel = cfg_sel_r;

    if (cfg_lines_r == 4'd0)                       eff_lines = 4'd1;
    else if (cfg_lines_r > 4'(MAX_INPUT_LINES))    eff_lines = 4'(MAX_INPUT_LINES);
    else                                           eff_lines = cfg_lines_r;

    sel_mask  = 5'((6'd1 << eff_sel) - 6'd1);
    count_raw = 9'(6'd1 << eff_sel) * 9'(eff_lines);
    sw_count  = (count_raw > 9'(MAX_SWITCHES)) ? SW_CNT_W'(MAX_SWITCHES)
                                               : count_raw[SW_CNT_W-1:0];
    settle_need = (cfg_settle_r == 8'd0) ? 8'd1 : cfg_settle_r;
  end

  // --------------------------------------------------------------------------
  // Flow control: middle stage and output register
  // --------------------------------------------------------------------------
  logic       s1_valid_r;
  mss_stage_t s1_r;
  logic       out_valid_r;
  logic       out_load;
  logic       in_acc;

  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  // Input fields
  logic [LVL_W-1:0]    in_levels;
  logic [LINE_W-1:0]   map_line;
  logic [SEL_W-1:0]    map_pin;
  logic [SW_IDX_W-1:0] map_number;

  assign in_levels  = in_tdata[7:0];
  assign map_line   = in_tdata[10:8];
  assign map_pin    = in_tdata[15:11];
  assign map_number = in_tdata[21:16];

  // --------------------------------------------------------------------------
  // Scan control (first stage)
  // --------------------------------------------------------------------------
  logic [SW_IDX_W-1:0] scan_index_r, scan_index_nxt;
  logic [7:0]          settle_count_r, settle_count_nxt;

  logic [SW_IDX_W-1:0] cur_idx;
  logic [7:0]          cur_settle;
  logic                sample;
  logic [LINE_W-1:0]   cur_line;
  logic                pressed;
  logic [SW_CNT_W-1:0] idx_inc;
  logic                tick_done;
  logic [7:0]          map_idx;
  logic                map_bad;
  logic                map_wr_en;
  mss_stage_t          s1_nxt;

  always_comb begin
    // Restart when a register change left the index past the scan
    if (SW_CNT_W'(scan_index_r) >= sw_count) begin
      cur_idx    = '0;
      cur_settle = 8'd0;
    end else begin
      cur_idx    = scan_index_r;
      cur_settle = settle_count_r;
    end

    sample    = (9'(cur_settle) + 9'd1) >= 9'(settle_need);
    // Only the low line bits pick a level
    cur_line  = LINE_W'(cur_idx >> eff_sel);
    pressed   = in_levels[cur_line] ^ cfg_neg_r;
    idx_inc   = SW_CNT_W'(cur_idx) + SW_CNT_W'(1);
    tick_done = sample && (idx_inc >= sw_count);

    map_idx   = (8'(map_line) << eff_sel) + 8'(map_pin);
    map_bad   = (4'(map_line) >= eff_lines) || (map_pin > sel_mask) ||
                (map_idx >= 8'(MAX_SWITCHES));
    map_wr_en = in_acc && (in_tuser == OP_MAP) && !map_bad;

    scan_index_nxt   = scan_index_r;
    settle_count_nxt = settle_count_r;
    s1_nxt.drive     = scan_index_r[SEL_W-1:0] & sel_mask;
    s1_nxt.done      = 1'b0;
    s1_nxt.hit       = 1'b0;
    s1_nxt.err       = 1'b0;

    if (in_tuser == OP_TICK) begin
      s1_nxt.drive = 5'(cur_idx) & sel_mask;
      if (sample) begin
        settle_count_nxt = 8'd0;
        scan_index_nxt   = tick_done ? '0 : idx_inc[SW_IDX_W-1:0];
        s1_nxt.hit       = pressed;
        s1_nxt.done      = tick_done;
      end else begin
        scan_index_nxt   = cur_idx;
        settle_count_nxt = cur_settle + 8'd1;
      end
    end else begin
      s1_nxt.err = map_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_index_r   <= '0;
      settle_count_r <= 8'd0;
      s1_valid_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        scan_index_r   <= scan_index_nxt;
        settle_count_r <= settle_count_nxt;
      end
      if (in_tready) s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= s1_nxt;
  end

  // --------------------------------------------------------------------------
  // Map memory: bit numbers in a RAM, valid flags in flops
  // --------------------------------------------------------------------------
  logic [SW_IDX_W-1:0]     map_num_mem [MAX_SWITCHES];
  logic [MAX_SWITCHES-1:0] map_vld_r;
  logic [SW_IDX_W-1:0]     s1_num_r;
  logic                    s1_vld_r;

  always_ff @(posedge clk) begin
    if (map_wr_en) map_num_mem[map_idx[SW_IDX_W-1:0]] <= map_number;
    if (in_acc)    s1_num_r <= map_num_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_vld_r <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      if (map_wr_en) map_vld_r[map_idx[SW_IDX_W-1:0]] <= 1'b1;
      if (in_acc)    s1_vld_r <= map_vld_r[cur_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Accumulate and publish (second stage), output register
  // --------------------------------------------------------------------------
  logic [STATE_W-1:0] acc_r, acc_nxt;
  logic [STATE_W-1:0] pub_r, pub_nxt;
  logic [STATE_W-1:0] acc_or;

  logic [SEL_W-1:0]   out_sel_r;
  logic               out_done_r;
  logic [STATE_W-1:0] out_state_r;
  logic               out_err_r;

  always_comb begin
    acc_or = acc_r;
    if (s1_r.hit && s1_vld_r) acc_or[s1_num_r] = 1'b1;
    if (s1_r.done) begin
      pub_nxt = acc_or;
      acc_nxt = '0;
    end else begin
      pub_nxt = pub_r;
      acc_nxt = acc_or;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        acc_r <= acc_nxt;
        pub_r <= pub_nxt;
      end
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sel_r   <= s1_r.drive;
      out_done_r  <= s1_r.done;
      out_state_r <= pub_nxt;
      out_err_r   <= s1_r.err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_err_r, out_state_r, out_sel_r};
  assign out_tlast  = out_done_r;

`ifndef SYNTHESIS
  // An accepted item always lands in the middle stage
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item did not reach middle stage");

  // Publishing a scan clears the accumulator
  a_done_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && s1_r.done) |=> (acc_r == '0))
    else $error("accumulator not cleared after scan end");

  // A good map write marks its entry valid
  a_map_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    map_wr_en |=> map_vld_r[$past(map_idx[SW_IDX_W-1:0])])
    else $error("map entry not marked valid");

  // A result is never both a scan end and a rejected map write
  a_done_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_done_r && out_err_r))
    else $error("scan_done and map_error on one result");

  // Publishing updates the visible state at once
  a_pub_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_state_r == pub_r))
    else $error("output state differs from published state");
`endif

endmodule

[sim/tb_mux_switch_scanner_unit.sv]
// ----------------------------------------------------------------------------
// tb_mux_switch_scanner_unit
// Self-checking bench: drives tick and map items, predicts every result.
// ----------------------------------------------------------------------------
// A table of directed items and register writes runs first, then phases of
// random items under changing register settings. Each accepted input item is
// passed through a local scanner model, and the expected result is queued;
// every accepted result is compared field by field with the oldest entry.
// Register writes happen only after the queue has drained.
// ----------------------------------------------------------------------------
module tb_mux_switch_scanner_unit
  import mss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Expected contents of one result item
  typedef struct packed {
    logic [4:0]  sel;
    logic        done;
    logic [63:0] state;
    logic        err;
  } scan_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} plan_kind_t;

  // One line of the directed plan: an item, or a register write
  typedef struct {
    plan_kind_t   kind;
    logic         op;
    logic [7:0]   levels;
    logic [2:0]   line;
    logic [4:0]   pin;
    logic [5:0]   number;
    logic [1:0]   addr;
    logic [7:0]   wdata;
    bit           typed;
    scan_result_t want;
  } plan_row_t;

  // Clock and block ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  // Scanner model: registers
  logic [2:0] m_sel_cnt;
  logic [3:0] m_line_cnt;
  logic       m_neg;
  logic [7:0] m_settle;
  // Scanner model: state
  int unsigned m_scan_pos;
  int unsigned m_settle_pos;
  logic [63:0] m_acc;
  logic [63:0] m_shown;
  logic        m_map_ok [MAX_SWITCHES];
  logic [5:0]  m_map_bit[MAX_SWITCHES];

  scan_result_t pending_results[$];
  plan_row_t    plan[$];
  int           fail_count = 0;
  int unsigned  tx_idle_pct = 23;
  int unsigned  rx_idle_pct = 80;

  always #2 clk = ~clk;

  mux_switch_scanner_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Effective select line count: zero acts as one, clamp to the maximum
  function automatic int unsigned eff_sel();
    int unsigned s;
    s = m_sel_cnt;
    if (s < 1) s = 1;
    if (s > MAX_SELECT_LINES) s = MAX_SELECT_LINES;
    return s;
  endfunction

  // Effective input line count, clamped the same way
  function automatic int unsigned eff_lines();
    int unsigned l;
    l = m_line_cnt;
    if (l < 1) l = 1;
    if (l > MAX_INPUT_LINES) l = MAX_INPUT_LINES;
    return l;
  endfunction

  function automatic void scanner_reset();
    m_sel_cnt = 3'd3;
    m_line_cnt = 4'd8;
    m_neg = 1'b1;
    m_settle = 8'd1;
    m_scan_pos = 0;
    m_settle_pos = 0;
    m_acc = '0;
    m_shown = '0;
    for (int i = 0; i < MAX_SWITCHES; i++) begin
      m_map_ok[i] = 1'b0;
      m_map_bit[i] = '0;
    end
  endfunction

  function automatic void scanner_reg_write(logic [1:0] addr, logic [7:0] data);
    case (addr)
      REG_SELECT_LINES: m_sel_cnt = data[2:0];
      REG_INPUT_LINES:  m_line_cnt = data[3:0];
      REG_NEG_LOGIC:    m_neg = data[0];
      REG_SETTLE_TICKS: m_settle = data;
      default: ;
    endcase
  endfunction

  // Advance the scanner model by one item and return the result it causes
  function automatic scan_result_t scanner_step(logic op, logic [7:0] levels,
                                                logic [2:0] line, logic [4:0] pin,
                                                logic [5:0] number);
    int unsigned s, l, count, needed, msk, src_line, idx;
    scan_result_t r;
    s = eff_sel();
    l = eff_lines();
    count = (1 << s) * l;
    if (count > MAX_SWITCHES) count = MAX_SWITCHES;
    msk = (1 << s) - 1;
    r = '0;
    if (op == OP_TICK) begin
      needed = (m_settle == 0) ? 1 : m_settle;
      // A register change may leave the scan past its end: restart first
      if (m_scan_pos >= count) begin
        m_scan_pos = 0;
        m_settle_pos = 0;
      end
      r.sel = 5'(m_scan_pos & msk);
      if (m_settle_pos + 1 >= needed) begin
        src_line = m_scan_pos >> s;
        if ((levels[src_line & 7] ^ m_neg) && m_map_ok[m_scan_pos % MAX_SWITCHES])
          m_acc = m_acc | (64'd1 << m_map_bit[m_scan_pos % MAX_SWITCHES]);
        m_settle_pos = 0;
        m_scan_pos++;
        if (m_scan_pos >= count) begin
          m_shown = m_acc;
          m_acc = '0;
          m_scan_pos = 0;
          r.done = 1'b1;
        end
      end else begin
        m_settle_pos++;
      end
    end else begin
      idx = (int'(line) << s) + pin;
      r.sel = 5'(m_scan_pos & msk);
      if (line >= l || pin > msk || idx >= MAX_SWITCHES) begin
        r.err = 1'b1;
      end else begin
        m_map_ok[idx] = 1'b1;
        m_map_bit[idx] = number;
      end
    end
    r.state = m_shown;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic op, logic [7:0] levels, logic [2:0] line,
                                         logic [4:0] pin, logic [5:0] number,
                                         bit typed = 1'b0, logic [4:0] w_sel = '0,
                                         logic w_done = 1'b0, logic [63:0] w_state = '0,
                                         logic w_err = 1'b0);
    plan_row_t row;
    row.kind = ROW_ITEM;
    row.op = op;
    row.levels = levels;
    row.line = line;
    row.pin = pin;
    row.number = number;
    row.addr = '0;
    row.wdata = '0;
    row.typed = typed;
    row.want.sel = w_sel;
    row.want.done = w_done;
    row.want.state = w_state;
    row.want.err = w_err;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [1:0] addr, logic [7:0] wdata);
    plan_row_t row;
    row = item_row(OP_TICK, '0, '0, '0, '0);
    row.kind = ROW_CFG;
    row.addr = addr;
    row.wdata = wdata;
    return row;
  endfunction

  // Present one item at a falling edge, hold it until taken, queue its result.
  // A typed expectation, where given, replaces the model's.
  task automatic send_item(logic op, logic [7:0] levels, logic [2:0] line,
                           logic [4:0] pin, logic [5:0] number,
                           bit typed = 1'b0, scan_result_t want = '0);
    scan_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, number, pin, line, levels};
    do @(posedge clk); while (!in_tready);
    r = scanner_step(op, levels, line, pin, number);
    pending_results.push_back(typed ? want : r);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write: one cycle of write enable; only called after drain()
  task automatic reg_write(logic [1:0] addr, logic [7:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    scanner_reg_write(addr, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver: stall at random, changing only at the falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $realtime, out_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("select_lines", 64'(want.sel), 64'(out_tdata[4:0]));
        check_field("scan_done", 64'(want.done), 64'(out_tlast));
        check_field("switch_state", want.state, out_tdata[68:5]);
        check_field("map_error", 64'(want.err), 64'(out_tdata[69]));
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned s, l;
    logic        op;
    logic [7:0]  lv;
    logic [2:0]  ln;
    logic [4:0]  pin;
    logic [5:0]  num;

    scanner_reset();

    // Directed plan; the comments give the register state each row sees.
    // Reset settings: 3 select lines, 8 input lines, negative logic, settle 1.
    plan.push_back(item_row(OP_TICK, 8'hFF, 3'd0, 5'd0, 6'd0, 1'b1, 5'd0, 1'b0, 64'd0, 1'b0));
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd7, 5'd7, 6'd63, 1'b1, 5'd1, 1'b0, 64'd0, 1'b0));
    // channel beyond the select range
    plan.push_back(item_row(OP_MAP, 8'hFF, 3'd0, 5'd8, 6'd5, 1'b1, 5'd1, 1'b0, 64'd0, 1'b1));
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd0, 5'd31, 6'd0, 1'b1, 5'd1, 1'b0, 64'd0, 1'b1));
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd0, 5'd1, 6'd0));
    plan.push_back(item_row(OP_TICK, 8'h00, 3'd7, 5'd31, 6'd63));
    // Zero counts act as one: two switches, scan index now past the end
    plan.push_back(cfg_row(REG_SELECT_LINES, 8'd0));
    plan.push_back(cfg_row(REG_INPUT_LINES, 8'd0));
    // line beyond the input line count
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd1, 5'd0, 6'd9, 1'b1, 5'd0, 1'b0, 64'd0, 1'b1));
    plan.push_back(item_row(OP_TICK, 8'h00, 3'd0, 5'd0, 6'd0));
    plan.push_back(item_row(OP_TICK, 8'h00, 3'd0, 5'd0, 6'd0));
    // Over-range counts clamp, scan clamps to 64; positive logic; zero settle
    plan.push_back(cfg_row(REG_SELECT_LINES, 8'd7));
    plan.push_back(cfg_row(REG_INPUT_LINES, 8'd15));
    plan.push_back(cfg_row(REG_NEG_LOGIC, 8'd0));
    plan.push_back(cfg_row(REG_SETTLE_TICKS, 8'd0));
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd1, 5'd31, 6'd33));
    // switch index past the clamped scan
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd2, 5'd0, 6'd1));
    // remap the same switch
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd1, 5'd31, 6'd62));
    plan.push_back(item_row(OP_TICK, 8'hFF, 3'd0, 5'd0, 6'd0));
    // Longest settle: ticks only count
    plan.push_back(cfg_row(REG_SETTLE_TICKS, 8'd255));
    plan.push_back(cfg_row(REG_SELECT_LINES, 8'd5));
    plan.push_back(cfg_row(REG_INPUT_LINES, 8'd8));
    plan.push_back(cfg_row(REG_NEG_LOGIC, 8'd1));
    for (int i = 0; i < 3; i++) plan.push_back(item_row(OP_TICK, 8'h00, 3'd0, 5'd0, 6'd0));
    // Two switches, settle of two: complete a few scans
    plan.push_back(cfg_row(REG_SELECT_LINES, 8'd1));
    plan.push_back(cfg_row(REG_INPUT_LINES, 8'd1));
    plan.push_back(cfg_row(REG_SETTLE_TICKS, 8'd2));
    plan.push_back(item_row(OP_MAP, 8'h00, 3'd0, 5'd0, 6'd63));
    for (int i = 0; i < 5; i++) plan.push_back(item_row(OP_TICK, 8'h00, 3'd0, 5'd0, 6'd0));
    plan.push_back(item_row(OP_TICK, 8'hFE, 3'd0, 5'd0, 6'd0));
    plan.push_back(item_row(OP_TICK, 8'h01, 3'd0, 5'd0, 6'd0));

    // Reset: hold it, then release at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) drain();
        reg_write(plan[i].addr, plan[i].wdata);
      end else begin
        send_item(plan[i].op, plan[i].levels, plan[i].line, plan[i].pin, plan[i].number,
                  plan[i].typed, plan[i].want);
      end
    end

    // Random phases: each picks new settings, then streams items
    for (int p = 0; p < 10; p++) begin
      drain();
      // sender idles little and receiver much, then the reverse, then no idling
      if (p < 4) begin
        tx_idle_pct = 23;
        rx_idle_pct = 80;
      end else if (p < 7) begin
        tx_idle_pct = 80;
        rx_idle_pct = 23;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p % 4)
        0: begin
          // smallest scans, zero or one settle tick
          reg_write(REG_SELECT_LINES, 8'($urandom_range(0, 1)));
          reg_write(REG_INPUT_LINES, 8'($urandom_range(0, 1)));
          reg_write(REG_NEG_LOGIC, 8'd0);
          reg_write(REG_SETTLE_TICKS, 8'($urandom_range(0, 1)));
        end
        1: begin
          reg_write(REG_SELECT_LINES, 8'($urandom_range(0, 7)));
          reg_write(REG_INPUT_LINES, 8'($urandom_range(0, 15)));
          reg_write(REG_NEG_LOGIC, 8'($urandom_range(0, 1)));
          reg_write(REG_SETTLE_TICKS, 8'($urandom_range(1, 3)));
        end
        2: begin
          // largest counts, clamped scan of 64 switches
          reg_write(REG_SELECT_LINES, 8'($urandom_range(5, 7)));
          reg_write(REG_INPUT_LINES, 8'($urandom_range(8, 15)));
          reg_write(REG_NEG_LOGIC, 8'd1);
          reg_write(REG_SETTLE_TICKS, 8'($urandom_range(0, 1)));
        end
        default: begin
          reg_write(REG_SELECT_LINES, 8'($urandom_range(0, 3)));
          reg_write(REG_INPUT_LINES, 8'($urandom_range(0, 4)));
          reg_write(REG_NEG_LOGIC, 8'($urandom_range(0, 1)));
          reg_write(REG_SETTLE_TICKS, 8'($urandom_range(0, 6)));
        end
      endcase
      s = eff_sel();
      l = eff_lines();
      for (int n = 0; n < 100; n++) begin
        // now and then hold off until the pipeline is empty
        if ($urandom_range(0, 49) == 0) drain();
        lv = 8'($urandom);
        ln = 3'($urandom);
        pin = 5'($urandom);
        num = 6'($urandom);
        op = ($urandom_range(0, 99) < 20) ? OP_MAP : OP_TICK;
        if (op == OP_MAP && $urandom_range(0, 99) < 85) begin
          // well-formed mapping within the current line and channel range
          ln = 3'($urandom_range(0, l - 1));
          pin = 5'($urandom_range(0, (1 << s) - 1));
        end else if (op == OP_TICK && $urandom_range(0, 9) == 0) begin
          lv = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        send_item(op, lv, ln, pin, num);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb_mux_switch_scanner_unit: clean");
    end else begin
      $display("tb_mux_switch_scanner_unit: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb_mux_switch_scanner_unit: errors");
    $finish;
  end

endmodule
